// ===== hw/rtl/mse_pkg.sv =====
`default_nettype none

package mse_pkg;

    // ln(2) as an unsigned Q0.64 fraction, used for the final 4*ln scaling.
    localparam logic [63:0] LN2_Q64 = 64'hB17217F7D1CF79AB;

    // Register index of the configuration port.
    typedef enum logic [1:0] {
        REG_MAX_ITER   = 2'd0,
        REG_ESC_LIMIT  = 2'd1,
        REG_PERIOD_EN  = 2'd2
    } cfg_idx_t;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_MUL,
        OP_ADD,
        OP_SUB,
        OP_ITER_INIT,
        OP_DEC,
        OP_PERIOD,
        OP_LOG_INIT,
        OP_LOG_NORM,
        OP_LOG_SQ,
        OP_LOG_END,
        OP_LN,
        OP_SM_ZERO,
        OP_EMIT
    } op_t;

    // Operand sources: working registers and fixed-point constants.
    typedef enum logic [3:0] {
        S_ZR,
        S_ZI,
        S_CR,
        S_CI,
        S_I2,
        S_T0,
        S_T1,
        S_T2,
        S_DIST,
        S_ONE,
        S_K8,
        S_K16,
        S_KM3,
        S_HALF,
        S_ZERO,
        S_NFIX
    } src_t;

    // Destinations of arithmetic results.
    typedef enum logic [2:0] {
        D_ZR,
        D_ZI,
        D_I2,
        D_T0,
        D_T1,
        D_T2,
        D_DIST
    } dst_t;

    typedef struct packed {
        op_t  op;
        src_t src_a;
        src_t src_b;
        dst_t dst;
    } dp_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic live;
        logic iter_zero;
        logic card_live;
        logic t0_pos;
        logic t1_pos;
        logic log_norm;
        logic log_last;
        logic log_nonpos;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mse_mul.sv =====
`default_nettype none

// Unsigned 64 x 64 multiplier built from one 32 x 32 multiplier, one partial
// product per cycle. The full 128-bit product is presented with done.
module mse_mul
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [63:0]  a,
    input  wire logic [63:0]  b,
    output logic              done,
    output logic [127:0]      prod
);
    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    logic [1:0]   cnt_reg, cnt_next;
    logic [63:0]  a_reg, a_next;
    logic [63:0]  b_reg, b_next;
    logic [127:0] acc_reg, acc_next;
    logic [31:0]  a_half;
    logic [31:0]  b_half;
    logic [63:0]  pp;
    logic [127:0] term;

    always_comb
    begin
        a_half = cnt_reg[1] ? a_reg[63:32] : a_reg[31:0];
        b_half = cnt_reg[0] ? b_reg[63:32] : b_reg[31:0];
        pp     = a_half * b_half;
        unique case (cnt_reg)
            2'd0:    term = {64'd0, pp};
            2'd3:    term = {pp, 64'd0};
            default: term = {32'd0, pp, 32'd0};
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        if (busy_reg)
        begin
            acc_next = acc_reg + term;
            cnt_next = cnt_reg + 2'd1;
            if (cnt_reg == 2'd3)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (start && !done_reg)
        begin
            busy_next = 1'b1;
            cnt_next  = 2'd0;
            a_next    = a;
            b_next    = b;
            acc_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/mse_dp.sv =====
`default_nettype none

// Datapath: working registers, saturating adder, shared multiplier,
// bit-serial logarithm registers, configuration and result registers.
module mse_dp
#(
    parameter int FRAC_BITS  = 44,
    parameter int ITER_WIDTH = 20
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [19:0]         cfg_data,
    input  wire logic [47:0]         c_real,
    input  wire logic [47:0]         c_imag,
    input  wire mse_pkg::dp_cmd_t    cmd,
    output mse_pkg::dp_status_t      status,
    output logic [31:0]              smooth_value,
    output logic                     inside_res,
    output logic [19:0]              iterations
);
    import mse_pkg::*;

    localparam logic [63:0] S_MAX   = {1'b0, {63{1'b1}}};
    localparam logic [63:0] S_MIN   = {1'b1, 63'd0};
    localparam logic [63:0] K_ONE   = 64'd1 << FRAC_BITS;
    localparam logic [63:0] K_8     = K_ONE << 3;
    localparam logic [63:0] K_16    = K_ONE << 4;
    localparam logic [63:0] K_M3    = 64'd0 - (K_ONE * 64'd3);
    localparam logic [63:0] K_HALFV = K_ONE >> 1;
    localparam logic [63:0] TH_E1   = (K_ONE >> 5) * 64'd3;
    localparam logic [63:0] TH_E2   = K_ONE >> 4;
    localparam int          LOG_CW  = $clog2(FRAC_BITS);
    localparam int          SM_SH   = 38 + FRAC_BITS;

    logic [ITER_WIDTH-1:0] max_iter_reg, max_iter_next;
    logic [15:0]           esc_reg, esc_next;
    logic                  pen_reg, pen_next;
    logic                  live_reg, live_next;

    logic [63:0] zr_reg, zr_next, zi_reg, zi_next;
    logic [63:0] cr_reg, cr_next, ci_reg, ci_next;
    logic [63:0] sr_reg, sr_next, si_reg, si_next;
    logic [63:0] i2_reg, i2_next;
    logic [63:0] t0_reg, t0_next, t1_reg, t1_next, t2_reg, t2_next;
    logic [63:0] dist_reg, dist_next;
    logic [ITER_WIDTH-1:0] iter_reg, iter_next, n_reg, n_next;
    logic [63:0]           lm_reg, lm_next;
    logic [5:0]            lp_reg, lp_next;
    logic [FRAC_BITS-1:0]  lf_reg, lf_next;
    logic [LOG_CW-1:0]     lc_reg, lc_next;
    logic                  lneg_reg, lneg_next;
    logic [31:0]           sm_reg, sm_next;
    logic [31:0]           out_sm_reg, out_sm_next;
    logic                  out_in_reg, out_in_next;
    logic [ITER_WIDTH-1:0] out_n_reg, out_n_next;

    logic [63:0]  opa, opb;
    logic [63:0]  mag_a, mag_b;
    logic [64:0]  wide_sum;
    logic [63:0]  alu_res;
    logic         mul_start, mul_done;
    logic [63:0]  mul_a, mul_b;
    logic [127:0] prod;
    logic         fx_neg, fx_ovf;
    logic [63:0]  fx_ql, fx_res;
    logic [63:0]  sq, sq_m;
    logic [31:0]  ln_res;
    logic [127:0] limit_w, nfix_w;
    logic [63:0]  limit, nfix;
    logic [63:0]  log_val;
    logic         dec_live, moment;
    logic [63:0]  wr_val;
    logic         wr_en;
    logic [ITER_WIDTH+19:0] n_wide;

    // Fixed-point conversions of whole numbers, saturated.
    always_comb
    begin
        limit_w = 128'(esc_reg) << FRAC_BITS;
        nfix_w  = 128'(n_reg) << FRAC_BITS;
        limit   = (|limit_w[127:63]) ? S_MAX : limit_w[63:0];
        nfix    = (|nfix_w[127:63]) ? S_MAX : nfix_w[63:0];
    end

    always_comb
    begin
        unique case (cmd.src_a)
            S_ZR:    opa = zr_reg;
            S_ZI:    opa = zi_reg;
            S_CR:    opa = cr_reg;
            S_CI:    opa = ci_reg;
            S_I2:    opa = i2_reg;
            S_T0:    opa = t0_reg;
            S_T1:    opa = t1_reg;
            S_T2:    opa = t2_reg;
            S_DIST:  opa = dist_reg;
            S_ONE:   opa = K_ONE;
            S_K8:    opa = K_8;
            S_K16:   opa = K_16;
            S_KM3:   opa = K_M3;
            S_HALF:  opa = K_HALFV;
            S_ZERO:  opa = 64'd0;
            S_NFIX:  opa = nfix;
            default: opa = 64'd0;
        endcase
        unique case (cmd.src_b)
            S_ZR:    opb = zr_reg;
            S_ZI:    opb = zi_reg;
            S_CR:    opb = cr_reg;
            S_CI:    opb = ci_reg;
            S_I2:    opb = i2_reg;
            S_T0:    opb = t0_reg;
            S_T1:    opb = t1_reg;
            S_T2:    opb = t2_reg;
            S_DIST:  opb = dist_reg;
            S_ONE:   opb = K_ONE;
            S_K8:    opb = K_8;
            S_K16:   opb = K_16;
            S_KM3:   opb = K_M3;
            S_HALF:  opb = K_HALFV;
            S_ZERO:  opb = 64'd0;
            S_NFIX:  opb = nfix;
            default: opb = 64'd0;
        endcase
    end

    // Saturating add or subtract on a 65-bit exact sum.
    always_comb
    begin
        if (cmd.op == OP_SUB)
            wide_sum = {opa[63], opa} - {opb[63], opb};
        else
            wide_sum = {opa[63], opa} + {opb[63], opb};
        if (wide_sum[64] != wide_sum[63])
            alu_res = wide_sum[64] ? S_MIN : S_MAX;
        else
            alu_res = wide_sum[63:0];
    end

    always_comb
    begin
        mag_a = opa[63] ? (64'd0 - opa) : opa;
        mag_b = opb[63] ? (64'd0 - opb) : opb;
        mul_start = 1'b0;
        mul_a     = mag_a;
        mul_b     = mag_b;
        unique case (cmd.op)
            OP_MUL:
            begin
                mul_start = 1'b1;
            end
            OP_LOG_SQ:
            begin
                mul_start = 1'b1;
                mul_a     = lm_reg;
                mul_b     = lm_reg;
            end
            OP_LN:
            begin
                mul_start = 1'b1;
                mul_a     = t0_reg;
                mul_b     = LN2_Q64;
            end
            default:
            begin
                mul_start = 1'b0;
            end
        endcase
    end

    mse_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (prod)
    );

    // Product post-processing for the three uses of the multiplier.
    always_comb
    begin
        fx_neg = opa[63] ^ opb[63];
        fx_ql  = prod[63+FRAC_BITS:FRAC_BITS];
        fx_ovf = (|prod[127:64+FRAC_BITS]) || fx_ql[63];
        if (fx_neg)
            fx_res = fx_ovf ? S_MIN : (64'd0 - fx_ql);
        else
            fx_res = fx_ovf ? S_MAX : fx_ql;
        sq     = prod[125:62];
        sq_m   = sq[63] ? (sq >> 1) : sq;
        ln_res = (|prod[127:SM_SH+32]) ? 32'hFFFF_FFFF : prod[SM_SH+31:SM_SH];
        log_val = ((64'(lp_reg) - 64'(FRAC_BITS)) << FRAC_BITS) | 64'(lf_reg);
        dec_live = (iter_reg != '0) && ($signed(dist_reg) < $signed(limit));
        moment   = (iter_reg & (iter_reg - 1'b1)) == '0;
    end

    always_comb
    begin
        max_iter_next = max_iter_reg;
        esc_next      = esc_reg;
        pen_next      = pen_reg;
        live_next     = live_reg;
        zr_next   = zr_reg;
        zi_next   = zi_reg;
        cr_next   = cr_reg;
        ci_next   = ci_reg;
        sr_next   = sr_reg;
        si_next   = si_reg;
        i2_next   = i2_reg;
        t0_next   = t0_reg;
        t1_next   = t1_reg;
        t2_next   = t2_reg;
        dist_next = dist_reg;
        iter_next = iter_reg;
        n_next    = n_reg;
        lm_next   = lm_reg;
        lp_next   = lp_reg;
        lf_next   = lf_reg;
        lc_next   = lc_reg;
        lneg_next = lneg_reg;
        sm_next   = sm_reg;
        out_sm_next = out_sm_reg;
        out_in_next = out_in_reg;
        out_n_next  = out_n_reg;
        wr_en  = 1'b0;
        wr_val = alu_res;

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MAX_ITER:  max_iter_next = ITER_WIDTH'(cfg_data);
                REG_ESC_LIMIT: esc_next      = cfg_data[15:0];
                REG_PERIOD_EN: pen_next      = cfg_data[0];
                default:       pen_next      = pen_reg;
            endcase
        end

        unique case (cmd.op)
            OP_LOAD:
            begin
                cr_next = {{16{c_real[47]}}, c_real};
                ci_next = {{16{c_imag[47]}}, c_imag};
                zr_next = {{16{c_real[47]}}, c_real};
                zi_next = {{16{c_imag[47]}}, c_imag};
                sr_next = {{16{c_real[47]}}, c_real};
                si_next = {{16{c_imag[47]}}, c_imag};
                n_next  = '0;
                live_next = 1'b0;
            end
            OP_MUL:
            begin
                wr_en  = mul_done;
                wr_val = fx_res;
            end
            OP_ADD, OP_SUB:
            begin
                wr_en = 1'b1;
            end
            OP_ITER_INIT:
            begin
                iter_next = status.card_live ? max_iter_reg : '0;
            end
            OP_DEC:
            begin
                live_next = dec_live;
                if (dec_live)
                begin
                    iter_next = iter_reg - 1'b1;
                    n_next    = n_reg + 1'b1;
                end
            end
            OP_PERIOD:
            begin
                if (pen_reg)
                begin
                    if (zr_reg == sr_reg && zi_reg == si_reg)
                        iter_next = '0;
                    if (moment)
                    begin
                        sr_next = zr_reg;
                        si_next = zi_reg;
                    end
                end
            end
            OP_LOG_INIT:
            begin
                lm_next   = opa;
                lp_next   = 6'd62;
                lf_next   = '0;
                lc_next   = LOG_CW'(FRAC_BITS - 1);
                lneg_next = opa[63] || (opa == 64'd0);
            end
            OP_LOG_NORM:
            begin
                if (!status.log_norm)
                begin
                    lm_next = lm_reg << 1;
                    lp_next = lp_reg - 6'd1;
                end
            end
            OP_LOG_SQ:
            begin
                if (mul_done)
                begin
                    lm_next         = sq_m;
                    lf_next[lc_reg] = sq[63];
                    lc_next         = lc_reg - 1'b1;
                end
            end
            OP_LOG_END:
            begin
                t0_next = lneg_reg ? S_MIN : log_val;
            end
            OP_LN:
            begin
                if (mul_done)
                    sm_next = ln_res;
            end
            OP_SM_ZERO:
            begin
                sm_next = 32'd0;
            end
            OP_EMIT:
            begin
                out_in_next = (iter_reg == '0);
                out_sm_next = (iter_reg == '0) ? 32'd0 : sm_reg;
                out_n_next  = n_reg;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase

        if (wr_en)
        begin
            unique case (cmd.dst)
                D_ZR:    zr_next   = wr_val;
                D_ZI:    zi_next   = wr_val;
                D_I2:    i2_next   = wr_val;
                D_T0:    t0_next   = wr_val;
                D_T1:    t1_next   = wr_val;
                D_T2:    t2_next   = wr_val;
                D_DIST:  dist_next = wr_val;
                default: t2_next   = t2_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_iter_reg <= ITER_WIDTH'(256);
            esc_reg      <= 16'd4;
            pen_reg      <= 1'b1;
            live_reg     <= 1'b0;
        end
        else
        begin
            max_iter_reg <= max_iter_next;
            esc_reg      <= esc_next;
            pen_reg      <= pen_next;
            live_reg     <= live_next;
        end
    end

    always_ff @(posedge clk)
    begin
        zr_reg   <= zr_next;
        zi_reg   <= zi_next;
        cr_reg   <= cr_next;
        ci_reg   <= ci_next;
        sr_reg   <= sr_next;
        si_reg   <= si_next;
        i2_reg   <= i2_next;
        t0_reg   <= t0_next;
        t1_reg   <= t1_next;
        t2_reg   <= t2_next;
        dist_reg <= dist_next;
        iter_reg <= iter_next;
        n_reg    <= n_next;
        lm_reg   <= lm_next;
        lp_reg   <= lp_next;
        lf_reg   <= lf_next;
        lc_reg   <= lc_next;
        lneg_reg <= lneg_next;
        sm_reg   <= sm_next;
        out_sm_reg <= out_sm_next;
        out_in_reg <= out_in_next;
        out_n_reg  <= out_n_next;
    end

    always_comb
    begin
        status.mul_done   = mul_done;
        status.live       = live_reg;
        status.iter_zero  = (iter_reg == '0);
        status.card_live  = ($signed(t0_reg) >= $signed(TH_E1)) &&
                            ($signed(t1_reg) >= $signed(TH_E2));
        status.t0_pos     = !t0_reg[63] && (t0_reg != 64'd0);
        status.t1_pos     = !t1_reg[63] && (t1_reg != 64'd0);
        status.log_norm   = lm_reg[62] || (lp_reg == 6'd0);
        status.log_last   = (lc_reg == '0);
        status.log_nonpos = lneg_reg;
    end

    assign n_wide       = {20'd0, out_n_reg};
    assign iterations   = n_wide[19:0];
    assign smooth_value = out_sm_reg;
    assign inside_res   = out_in_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/mse_ctrl.sv =====
`default_nettype none

// Controller: walks the datapath through the bulb test, the iteration loop,
// the three logarithms and final scaling, at most one operation per state.
module mse_ctrl
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic                m_tready,
    output logic                     m_tvalid,
    input  wire mse_pkg::dp_status_t status,
    output mse_pkg::dp_cmd_t         cmd
);
    import mse_pkg::*;

    typedef enum logic [40:0] {
        ST_IDLE    = 41'd1 << 0,
        ST_C_I2    = 41'd1 << 1,
        ST_C_R2    = 41'd1 << 2,
        ST_C_A1    = 41'd1 << 3,
        ST_C_A2    = 41'd1 << 4,
        ST_C_A3    = 41'd1 << 5,
        ST_C_A4    = 41'd1 << 6,
        ST_C_B1    = 41'd1 << 7,
        ST_C_B2    = 41'd1 << 8,
        ST_C_B3    = 41'd1 << 9,
        ST_C_B4    = 41'd1 << 10,
        ST_C_E1    = 41'd1 << 11,
        ST_C_E2    = 41'd1 << 12,
        ST_C_E3    = 41'd1 << 13,
        ST_C_E4    = 41'd1 << 14,
        ST_C_E5    = 41'd1 << 15,
        ST_C_DEC   = 41'd1 << 16,
        ST_IT_SQ   = 41'd1 << 17,
        ST_IT_DIST = 41'd1 << 18,
        ST_IT_DEC  = 41'd1 << 19,
        ST_IT_XY   = 41'd1 << 20,
        ST_IT_X2   = 41'd1 << 21,
        ST_IT_XC   = 41'd1 << 22,
        ST_IT_RS   = 41'd1 << 23,
        ST_IT_RN   = 41'd1 << 24,
        ST_IT_MV   = 41'd1 << 25,
        ST_IT_I2   = 41'd1 << 26,
        ST_IT_PER  = 41'd1 << 27,
        ST_FIN     = 41'd1 << 28,
        ST_LG_INIT = 41'd1 << 29,
        ST_LG_NORM = 41'd1 << 30,
        ST_LG_SQ   = 41'd1 << 31,
        ST_LG_END  = 41'd1 << 32,
        ST_SM_HALF = 41'd1 << 33,
        ST_SM_A1   = 41'd1 << 34,
        ST_SM_A2   = 41'd1 << 35,
        ST_SM_CHK  = 41'd1 << 36,
        ST_SM_CHK2 = 41'd1 << 37,
        ST_SM_LN   = 41'd1 << 38,
        ST_SM_ZERO = 41'd1 << 39,
        ST_OUT     = 41'd1 << 40
    } state_t;

    typedef enum logic [1:0] {
        PH_LA,
        PH_LB,
        PH_LG
    } phase_t;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    logic   m_tvalid_reg, m_tvalid_next;

    function automatic dp_cmd_t mk(op_t op, src_t a, src_t b, dst_t d);
        dp_cmd_t c;
        c.op    = op;
        c.src_a = a;
        c.src_b = b;
        c.dst   = d;
        return c;
    endfunction

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        cmd        = mk(OP_NOP, S_ZERO, S_ZERO, D_T0);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd        = mk(OP_LOAD, S_ZERO, S_ZERO, D_T0);
                    state_next = ST_C_I2;
                end
            end
            ST_C_I2:
            begin
                cmd = mk(OP_MUL, S_ZI, S_ZI, D_I2);
                if (status.mul_done) state_next = ST_C_R2;
            end
            ST_C_R2:
            begin
                cmd = mk(OP_MUL, S_ZR, S_ZR, D_T2);
                if (status.mul_done) state_next = ST_C_A1;
            end
            ST_C_A1:
            begin
                cmd = mk(OP_MUL, S_I2, S_K8, D_T0);
                if (status.mul_done) state_next = ST_C_A2;
            end
            ST_C_A2:
            begin
                cmd = mk(OP_MUL, S_T2, S_K16, D_T1);
                if (status.mul_done) state_next = ST_C_A3;
            end
            ST_C_A3:
            begin
                cmd        = mk(OP_ADD, S_T1, S_KM3, D_T1);
                state_next = ST_C_A4;
            end
            ST_C_A4:
            begin
                cmd        = mk(OP_ADD, S_T0, S_T1, D_T0);
                state_next = ST_C_B1;
            end
            ST_C_B1:
            begin
                cmd = mk(OP_MUL, S_T2, S_K8, D_T1);
                if (status.mul_done) state_next = ST_C_B2;
            end
            ST_C_B2:
            begin
                cmd        = mk(OP_ADD, S_T1, S_KM3, D_T1);
                state_next = ST_C_B3;
            end
            ST_C_B3:
            begin
                cmd = mk(OP_MUL, S_T2, S_T1, D_T1);
                if (status.mul_done) state_next = ST_C_B4;
            end
            ST_C_B4:
            begin
                cmd        = mk(OP_ADD, S_T1, S_ZR, D_T1);
                state_next = ST_C_E1;
            end
            ST_C_E1:
            begin
                cmd = mk(OP_MUL, S_I2, S_T0, D_T0);
                if (status.mul_done) state_next = ST_C_E2;
            end
            ST_C_E2:
            begin
                cmd        = mk(OP_ADD, S_T0, S_T1, D_T0);
                state_next = ST_C_E3;
            end
            ST_C_E3:
            begin
                cmd        = mk(OP_ADD, S_ZR, S_ONE, D_T1);
                state_next = ST_C_E4;
            end
            ST_C_E4:
            begin
                cmd = mk(OP_MUL, S_T1, S_T1, D_T1);
                if (status.mul_done) state_next = ST_C_E5;
            end
            ST_C_E5:
            begin
                cmd        = mk(OP_ADD, S_T1, S_I2, D_T1);
                state_next = ST_C_DEC;
            end
            ST_C_DEC:
            begin
                cmd        = mk(OP_ITER_INIT, S_ZERO, S_ZERO, D_T0);
                state_next = status.card_live ? ST_IT_SQ : ST_OUT;
            end
            ST_IT_SQ:
            begin
                cmd = mk(OP_MUL, S_ZR, S_ZR, D_T0);
                if (status.mul_done) state_next = ST_IT_DIST;
            end
            ST_IT_DIST:
            begin
                cmd        = mk(OP_ADD, S_T0, S_I2, D_DIST);
                state_next = ST_IT_DEC;
            end
            ST_IT_DEC:
            begin
                cmd        = mk(OP_DEC, S_ZERO, S_ZERO, D_T0);
                state_next = ST_IT_XY;
            end
            ST_IT_XY:
            begin
                cmd = mk(OP_MUL, S_ZR, S_ZI, D_T1);
                if (status.mul_done) state_next = ST_IT_X2;
            end
            ST_IT_X2:
            begin
                cmd        = mk(OP_ADD, S_T1, S_T1, D_T1);
                state_next = ST_IT_XC;
            end
            ST_IT_XC:
            begin
                cmd        = mk(OP_ADD, S_T1, S_CI, D_T1);
                state_next = ST_IT_RS;
            end
            ST_IT_RS:
            begin
                cmd        = mk(OP_SUB, S_CR, S_I2, D_T2);
                state_next = ST_IT_RN;
            end
            ST_IT_RN:
            begin
                cmd        = mk(OP_ADD, S_T0, S_T2, D_ZR);
                state_next = ST_IT_MV;
            end
            ST_IT_MV:
            begin
                cmd        = mk(OP_ADD, S_T1, S_ZERO, D_ZI);
                state_next = ST_IT_I2;
            end
            ST_IT_I2:
            begin
                cmd = mk(OP_MUL, S_ZI, S_ZI, D_I2);
                if (status.mul_done) state_next = ST_IT_PER;
            end
            ST_IT_PER:
            begin
                cmd        = mk(OP_PERIOD, S_ZERO, S_ZERO, D_T0);
                state_next = status.live ? ST_IT_SQ : ST_FIN;
            end
            ST_FIN:
            begin
                if (status.iter_zero)
                    state_next = ST_OUT;
                else
                begin
                    phase_next = PH_LA;
                    state_next = ST_LG_INIT;
                end
            end
            ST_LG_INIT:
            begin
                unique case (phase_reg)
                    PH_LA:   cmd = mk(OP_LOG_INIT, S_DIST, S_ZERO, D_T0);
                    PH_LB:   cmd = mk(OP_LOG_INIT, S_T0, S_ZERO, D_T0);
                    default: cmd = mk(OP_LOG_INIT, S_T1, S_ZERO, D_T0);
                endcase
                state_next = ST_LG_NORM;
            end
            ST_LG_NORM:
            begin
                cmd = mk(OP_LOG_NORM, S_ZERO, S_ZERO, D_T0);
                priority if (status.log_nonpos)
                    state_next = ST_LG_END;
                else if (status.log_norm)
                    state_next = ST_LG_SQ;
            end
            ST_LG_SQ:
            begin
                cmd = mk(OP_LOG_SQ, S_ZERO, S_ZERO, D_T0);
                if (status.mul_done && status.log_last) state_next = ST_LG_END;
            end
            ST_LG_END:
            begin
                cmd = mk(OP_LOG_END, S_ZERO, S_ZERO, D_T0);
                unique case (phase_reg)
                    PH_LA:   state_next = ST_SM_HALF;
                    PH_LB:   state_next = ST_SM_A1;
                    default: state_next = ST_SM_CHK2;
                endcase
            end
            ST_SM_HALF:
            begin
                cmd = mk(OP_MUL, S_T0, S_HALF, D_T0);
                if (status.mul_done)
                begin
                    phase_next = PH_LB;
                    state_next = ST_LG_INIT;
                end
            end
            ST_SM_A1:
            begin
                cmd        = mk(OP_SUB, S_ONE, S_T0, D_T1);
                state_next = ST_SM_A2;
            end
            ST_SM_A2:
            begin
                cmd        = mk(OP_ADD, S_NFIX, S_T1, D_T1);
                state_next = ST_SM_CHK;
            end
            ST_SM_CHK:
            begin
                if (status.t1_pos)
                begin
                    phase_next = PH_LG;
                    state_next = ST_LG_INIT;
                end
                else
                    state_next = ST_SM_ZERO;
            end
            ST_SM_CHK2:
            begin
                state_next = status.t0_pos ? ST_SM_LN : ST_SM_ZERO;
            end
            ST_SM_LN:
            begin
                cmd = mk(OP_LN, S_ZERO, S_ZERO, D_T0);
                if (status.mul_done) state_next = ST_OUT;
            end
            ST_SM_ZERO:
            begin
                cmd        = mk(OP_SM_ZERO, S_ZERO, S_ZERO, D_T0);
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    cmd        = mk(OP_EMIT, S_ZERO, S_ZERO, D_T0);
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.op == OP_EMIT)
            m_tvalid_next = 1'b1;
        else
            m_tvalid_next = m_tvalid_reg && !m_tready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            phase_reg    <= PH_LA;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

`ifndef NO_ASSERTIONS
    a_done_only_when_multiplying: assert property (@(posedge clk) disable iff (!rst_n)
        status.mul_done |-> (cmd.op == OP_MUL || cmd.op == OP_LOG_SQ || cmd.op == OP_LN))
        else $error("multiplier finished outside a multiply step");

    a_emit_raises_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_EMIT) |=> m_tvalid_reg)
        else $error("result register not marked valid after emit");

    a_idle_multiplier_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !status.mul_done)
        else $error("multiplier result arrived while idle");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/mandelbrot_smooth_escape_top.sv =====
`default_nettype none

// Mandelbrot point evaluator with a smooth escape value. Each request on the
// input stream carries one point c (Q4.44 real and imaginary parts); the block
// runs the main-cardioid and period-2-bulb test, then iterates z = z*z + c in
// saturating Q20.44 arithmetic until |z|^2 reaches the escape limit, the
// iteration budget runs out, or z exactly repeats the value saved when the
// remaining budget was last a power of two (when periodicity detection is
// enabled). One result request follows per point: the smooth value
// 4*ln(n + 1 - log2(log2|z|)) in unsigned Q8.24, zero for points judged
// inside, the inside flag and the iteration count. Points are handled one at
// a time. Every fixed-point product goes through a single shared 32 x 32
// multiplier in four partial products. The default iteration budget is 256.
// Each of the three logarithms starts with a leading-one normalization. The
// result waits in an output register, so a new point is taken while the
// previous result is still pending. The configuration port writes registers
// on any clock edge with the write enable high; it is to be used only while
// no point is in flight.
module mandelbrot_smooth_escape_top
#(
    parameter int FRAC_BITS  = 44,
    parameter int ITER_WIDTH = 20
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    // Configuration write port: index 0 max_iterations, 1 escape_limit_sq,
    // 2 periodicity_enable.
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [19:0]  cfg_data,
    // Input stream. s_tdata, from bit 0 up: c_real[47:0], c_imag[47:0].
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [95:0]  s_tdata,
    // Output stream. m_tdata, from bit 0 up: smooth_value[31:0],
    // iterations[19:0], four zero bits. m_tuser: inside_res.
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [55:0]       m_tdata,
    output logic              m_tuser
);
    import mse_pkg::*;

    dp_cmd_t     cmd;
    dp_status_t  status;
    logic [31:0] smooth_value;
    logic        inside_res;
    logic [19:0] iterations;

    // The controller sequences every step; the datapath only executes them.
    mse_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .status   (status),
        .cmd      (cmd)
    );

    mse_dp
    #(
        .FRAC_BITS  (FRAC_BITS),
        .ITER_WIDTH (ITER_WIDTH)
    )
    u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .c_real       (s_tdata[47:0]),
        .c_imag       (s_tdata[95:48]),
        .cmd          (cmd),
        .status       (status),
        .smooth_value (smooth_value),
        .inside_res   (inside_res),
        .iterations   (iterations)
    );

    assign m_tdata = {4'd0, iterations, smooth_value};
    assign m_tuser = inside_res;

endmodule

`default_nettype wire
